@@ rtl/loud_sound_spike_detector_top_defines.svh @@
// Assertion macros shared by the checker of the loud sound spike detector.
// Depends on nothing; each macro expects a clock aclk; LSSD_ASSERT_CLK expects aresetn.
`ifndef LOUD_SOUND_SPIKE_DETECTOR_TOP_DEFINES_SVH
`define LOUD_SOUND_SPIKE_DETECTOR_TOP_DEFINES_SVH

// Checked only while the block is out of reset.
`define LSSD_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define LSSD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/lssd_pkg.sv @@
// Types and constants of the loud sound spike detector.
// Depends on nothing; used by the top level and its checker.
package lssd_pkg;

    localparam int unsigned SampleW = 16;
    localparam int unsigned AvgW    = 24;
    localparam int unsigned RatioW  = 8;
    localparam int unsigned ProdW   = 33;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDatW = 16;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] RegSpikeRatio  = 3'd0;
    localparam logic [CfgIdxW-1:0] RegGateRatio   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegMinPeak     = 3'd2;
    localparam logic [CfgIdxW-1:0] RegNoiseFloor  = 3'd3;
    localparam logic [CfgIdxW-1:0] RegAdaptWeight = 3'd4;
    localparam logic [CfgIdxW-1:0] RegRefractory  = 3'd5;

    // Reset values.
    localparam logic [RatioW-1:0]  SpikeRatioRst  = 8'd48;
    localparam logic [RatioW-1:0]  GateRatioRst   = 8'd32;
    localparam logic [SampleW-1:0] MinPeakRst     = 16'd3000;
    localparam logic [SampleW-1:0] NoiseFloorRst  = 16'd500;
    localparam logic [RatioW-1:0]  AdaptWeightRst = 8'd13;
    localparam logic [SampleW-1:0] RefractoryRst  = 16'd800;
    localparam logic [AvgW-1:0]    NoiseAvgRst    = 24'd128000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATE,
        ST_ADAPT_A,
        ST_ADAPT_B,
        ST_UPDATE,
        ST_CLAMP,
        ST_SPIKE,
        ST_DONE
    } state_t;

endpackage

@@ rtl/loud_sound_spike_detector_top.sv @@
// Loud sound spike detector: peak tracking, adaptive noise average and refractory hold.
// Depends on lssd_pkg; all products go through one shared 24x9 multiplier.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------------
//  s_*      | in        | s_valid / s_ready  | s_command, s_sample, s_last_of_block
//  m_*      | out       | m_valid / m_ready  | m_loud, m_block_peak, m_noise_level
//  cfg_*    | in        | cfg_we             | cfg_index, cfg_wdata
//
// A tick or a sample that does not close a block is taken and leaves s_ready high.
// A block end keeps s_ready low through GATE, ADAPT_A, ADAPT_B, UPDATE, CLAMP, SPIKE and
// DONE (DONE alone when the peak is zero): the single multiplier forms the gate product
// and both update products, the average is updated and clamped, and the multiplier then
// forms the spike product. DONE waits while the prior result is held on the m_ channel.
// Synchronous active-low aresetn restores the control registers and the noise average.
module loud_sound_spike_detector_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command,
    input  logic signed [lssd_pkg::SampleW-1:0] s_sample,
    input  logic                               s_last_of_block,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_loud,
    output logic [lssd_pkg::SampleW-1:0]       m_block_peak,
    output logic [lssd_pkg::SampleW-1:0]       m_noise_level,
    input  logic                               cfg_we,
    input  logic [lssd_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [lssd_pkg::CfgDatW-1:0]       cfg_wdata
);

    lssd_pkg::state_t state_reg, state_next;

    logic [lssd_pkg::RatioW-1:0]  spike_ratio_reg, spike_ratio_next;
    logic [lssd_pkg::RatioW-1:0]  gate_ratio_reg, gate_ratio_next;
    logic [lssd_pkg::SampleW-1:0] min_peak_reg, min_peak_next;
    logic [lssd_pkg::SampleW-1:0] noise_floor_reg, noise_floor_next;
    logic [lssd_pkg::RatioW-1:0]  adapt_weight_reg, adapt_weight_next;
    logic [lssd_pkg::SampleW-1:0] refractory_reg, refractory_next;

    logic [lssd_pkg::SampleW-1:0] running_peak_reg, running_peak_next;
    logic [lssd_pkg::SampleW-1:0] blk_peak_reg, blk_peak_next;
    logic [lssd_pkg::AvgW-1:0]    noise_avg_reg, noise_avg_next;
    logic [lssd_pkg::SampleW-1:0] hold_left_reg, hold_left_next;
    logic                         adapt_reg, adapt_next;
    logic [lssd_pkg::ProdW-1:0]   acc_reg, acc_next;
    logic [lssd_pkg::ProdW-1:0]   prod_reg, prod_next;

    logic                         m_valid_reg, m_valid_next;
    logic                         m_loud_reg, m_loud_next;
    logic [lssd_pkg::SampleW-1:0] m_peak_reg, m_peak_next;
    logic [lssd_pkg::SampleW-1:0] m_level_reg, m_level_next;

    logic [lssd_pkg::AvgW-1:0]    mul_a;
    logic [8:0]                   mul_b;
    logic [lssd_pkg::ProdW-1:0]   mul_p;
    logic [lssd_pkg::SampleW-1:0] mag;
    logic [lssd_pkg::SampleW-1:0] new_peak;
    logic [lssd_pkg::ProdW-1:0]   peak_q12;
    logic [25:0]                  upd_sum;
    logic [lssd_pkg::AvgW-1:0]    floor_q8;
    logic                         accept;
    logic                         out_free;
    logic                         loud;

    assign s_ready       = (state_reg == lssd_pkg::ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign out_free      = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_loud        = m_loud_reg;
    assign m_block_peak  = m_peak_reg;
    assign m_noise_level = m_level_reg;

    // The most negative sample maps to 32768, which still fits 16 unsigned bits.
    assign mag      = s_sample[lssd_pkg::SampleW-1] ? (~s_sample + 16'd1) : s_sample;
    assign new_peak = (mag > running_peak_reg) ? mag : running_peak_reg;
    assign peak_q12 = {5'd0, blk_peak_reg, 12'd0};
    assign upd_sum  = {1'b0, acc_reg[32:8]} + {2'd0, prod_reg[23:0]};
    assign floor_q8 = {noise_floor_reg, 8'd0};
    assign loud     = (hold_left_reg == '0) && (peak_q12 > prod_reg)
                      && (blk_peak_reg > min_peak_reg);

    // Shared multiplier operand selection.
    always_comb begin
        unique case (state_reg)
            lssd_pkg::ST_GATE: begin
                mul_a = noise_avg_reg;
                mul_b = {1'b0, gate_ratio_reg};
            end
            lssd_pkg::ST_ADAPT_A: begin
                mul_a = noise_avg_reg;
                mul_b = 9'd256 - {1'b0, adapt_weight_reg};
            end
            lssd_pkg::ST_ADAPT_B: begin
                mul_a = {8'd0, blk_peak_reg};
                mul_b = {1'b0, adapt_weight_reg};
            end
            lssd_pkg::ST_SPIKE: begin
                mul_a = noise_avg_reg;
                mul_b = {1'b0, spike_ratio_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {9'd0, mul_a} * {24'd0, mul_b};

    always_comb begin
        state_next        = state_reg;
        spike_ratio_next  = spike_ratio_reg;
        gate_ratio_next   = gate_ratio_reg;
        min_peak_next     = min_peak_reg;
        noise_floor_next  = noise_floor_reg;
        adapt_weight_next = adapt_weight_reg;
        refractory_next   = refractory_reg;
        running_peak_next = running_peak_reg;
        blk_peak_next     = blk_peak_reg;
        noise_avg_next    = noise_avg_reg;
        hold_left_next    = hold_left_reg;
        adapt_next        = adapt_reg;
        acc_next          = acc_reg;
        prod_next         = prod_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_loud_next       = m_loud_reg;
        m_peak_next       = m_peak_reg;
        m_level_next      = m_level_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                lssd_pkg::RegSpikeRatio:  spike_ratio_next  = cfg_wdata[7:0];
                lssd_pkg::RegGateRatio:   gate_ratio_next   = cfg_wdata[7:0];
                lssd_pkg::RegMinPeak:     min_peak_next     = cfg_wdata;
                lssd_pkg::RegNoiseFloor:  noise_floor_next  = cfg_wdata;
                lssd_pkg::RegAdaptWeight: adapt_weight_next = cfg_wdata[7:0];
                lssd_pkg::RegRefractory:  refractory_next   = cfg_wdata;
                default: ;
            endcase
        end

        unique case (state_reg)
            lssd_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_command) begin
                        if (hold_left_reg != '0) begin
                            hold_left_next = hold_left_reg - 16'd1;
                        end
                    end else if (s_last_of_block) begin
                        blk_peak_next     = new_peak;
                        running_peak_next = '0;
                        // A silent block skips the update; its spike test fails on its own.
                        state_next = (new_peak == '0) ? lssd_pkg::ST_DONE
                                                      : lssd_pkg::ST_GATE;
                    end else begin
                        running_peak_next = new_peak;
                    end
                end
            end
            lssd_pkg::ST_GATE: begin
                prod_next  = mul_p;
                state_next = lssd_pkg::ST_ADAPT_A;
            end
            lssd_pkg::ST_ADAPT_A: begin
                adapt_next = peak_q12 < prod_reg;
                prod_next  = mul_p;
                state_next = lssd_pkg::ST_ADAPT_B;
            end
            lssd_pkg::ST_ADAPT_B: begin
                acc_next   = prod_reg;
                prod_next  = mul_p;
                state_next = lssd_pkg::ST_UPDATE;
            end
            lssd_pkg::ST_UPDATE: begin
                // The peak term has zero low bits, so the shift distributes over the sum.
                if (adapt_reg) begin
                    noise_avg_next = upd_sum[23:0];
                end
                state_next = lssd_pkg::ST_CLAMP;
            end
            lssd_pkg::ST_CLAMP: begin
                if (noise_avg_reg < floor_q8) begin
                    noise_avg_next = floor_q8;
                end
                state_next = lssd_pkg::ST_SPIKE;
            end
            lssd_pkg::ST_SPIKE: begin
                prod_next  = mul_p;
                state_next = lssd_pkg::ST_DONE;
            end
            lssd_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_loud_next  = loud;
                    m_peak_next  = blk_peak_reg;
                    m_level_next = noise_avg_reg[23:8];
                    if (loud) begin
                        hold_left_next = refractory_reg;
                    end
                    state_next = lssd_pkg::ST_IDLE;
                end
            end
            default: state_next = lssd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= lssd_pkg::ST_IDLE;
            spike_ratio_reg  <= lssd_pkg::SpikeRatioRst;
            gate_ratio_reg   <= lssd_pkg::GateRatioRst;
            min_peak_reg     <= lssd_pkg::MinPeakRst;
            noise_floor_reg  <= lssd_pkg::NoiseFloorRst;
            adapt_weight_reg <= lssd_pkg::AdaptWeightRst;
            refractory_reg   <= lssd_pkg::RefractoryRst;
            running_peak_reg <= '0;
            noise_avg_reg    <= lssd_pkg::NoiseAvgRst;
            hold_left_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            spike_ratio_reg  <= spike_ratio_next;
            gate_ratio_reg   <= gate_ratio_next;
            min_peak_reg     <= min_peak_next;
            noise_floor_reg  <= noise_floor_next;
            adapt_weight_reg <= adapt_weight_next;
            refractory_reg   <= refractory_next;
            running_peak_reg <= running_peak_next;
            noise_avg_reg    <= noise_avg_next;
            hold_left_reg    <= hold_left_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        blk_peak_reg <= blk_peak_next;
        adapt_reg    <= adapt_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        m_loud_reg   <= m_loud_next;
        m_peak_reg   <= m_peak_next;
        m_level_reg  <= m_level_next;
    end

endmodule

@@ rtl/lssd_checker.sv @@
// Port-level checker for the loud sound spike detector, bound to the top level.
// Depends on lssd_pkg and loud_sound_spike_detector_top_defines.svh.
`include "loud_sound_spike_detector_top_defines.svh"

module lssd_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                s_command,
    input logic signed [lssd_pkg::SampleW-1:0] s_sample,
    input logic                                s_last_of_block,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_loud,
    input logic [lssd_pkg::SampleW-1:0]        m_block_peak,
    input logic [lssd_pkg::SampleW-1:0]        m_noise_level
);

    logic [2*lssd_pkg::SampleW:0]   out_payload;
    logic [lssd_pkg::SampleW+1:0]   in_payload;

    assign out_payload = {m_loud, m_block_peak, m_noise_level};
    assign in_payload  = {s_command, s_sample, s_last_of_block};

    property p_out_hold;
        m_valid && !m_ready |=> m_valid && $stable(out_payload);
    endproperty

    property p_in_hold;
        s_valid && !s_ready |=> s_valid && $stable(in_payload);
    endproperty

    property p_rst_empty;
        !aresetn |=> !m_valid;
    endproperty

    property p_loud_peak;
        m_valid && m_loud |-> m_block_peak != '0;
    endproperty

    property p_block_busy;
        s_valid && s_ready && !s_command && s_last_of_block |=> !s_ready;
    endproperty

    // A held result keeps its payload until it is taken.
    `LSSD_ASSERT_CLK(a_out_hold, p_out_hold, "result item changed while stalled")

    // A waiting input item keeps its payload until it is taken.
    `LSSD_ASSERT_CLK(a_in_hold, p_in_hold, "input item changed while waiting")

    // Reset empties the result register.
    `LSSD_ASSERT_ALWAYS(a_rst_empty, p_rst_empty, "result item present after reset")

    // A loud report always carries a nonzero peak.
    `LSSD_ASSERT_CLK(a_loud_peak, p_loud_peak, "loud item with zero peak")

    // A sample that closes a block makes the block busy on the next cycle.
    `LSSD_ASSERT_CLK(a_block_busy, p_block_busy, "ready stayed high after a block end")

endmodule

bind loud_sound_spike_detector_top lssd_checker u_lssd_checker (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for loud_sound_spike_detector_top: sample and tick traffic with
// random gaps and stalls, checked against a built-in noise-average and spike predictor.
// Depends on lssd_pkg and the top level of the detector.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CmdSample = 1'b0;
    localparam logic CmdTick   = 1'b1;

    // Indexes past the last register; writes there must change nothing.
    localparam logic [lssd_pkg::CfgIdxW-1:0] RegSpareLo = 3'd6;
    localparam logic [lssd_pkg::CfgIdxW-1:0] RegSpareHi = 3'd7;

    localparam int CycleLimit = 300000;
    localparam int SettleCycles = 12;

    typedef struct packed {
        logic                         cmd;
        logic [lssd_pkg::SampleW-1:0] pcm;
        logic                         closes;
    } mic_item_t;

    typedef struct packed {
        logic                         loud;
        logic [lssd_pkg::SampleW-1:0] peak;
        logic [lssd_pkg::SampleW-1:0] level;
    } report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_command = 1'b0;
    logic [lssd_pkg::SampleW-1:0] s_sample = '0;
    logic s_last_of_block = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_loud;
    logic [lssd_pkg::SampleW-1:0] m_block_peak;
    logic [lssd_pkg::SampleW-1:0] m_noise_level;
    logic cfg_we = 1'b0;
    logic [lssd_pkg::CfgIdxW-1:0] cfg_index = '0;
    logic [lssd_pkg::CfgDatW-1:0] cfg_wdata = '0;

    // Register copies and detector state as the predictor sees them.
    logic [lssd_pkg::RatioW-1:0]  cfg_spike = lssd_pkg::SpikeRatioRst;
    logic [lssd_pkg::RatioW-1:0]  cfg_gate = lssd_pkg::GateRatioRst;
    logic [lssd_pkg::SampleW-1:0] cfg_min_peak = lssd_pkg::MinPeakRst;
    logic [lssd_pkg::SampleW-1:0] cfg_floor = lssd_pkg::NoiseFloorRst;
    logic [lssd_pkg::RatioW-1:0]  cfg_weight = lssd_pkg::AdaptWeightRst;
    logic [lssd_pkg::SampleW-1:0] cfg_refractory = lssd_pkg::RefractoryRst;
    logic [lssd_pkg::SampleW-1:0] peak_track = '0;
    logic [lssd_pkg::AvgW-1:0]    avg_q8 = lssd_pkg::NoiseAvgRst;
    logic [lssd_pkg::SampleW-1:0] hold_count = '0;

    mic_item_t mic_queue[$];
    report_t   pending_reports[$];

    int error_count = 0;
    int items_sent = 0;
    int reports_checked = 0;
    int loud_seen = 0;
    int adapt_steps = 0;
    int settings_used = 1;
    int cycle_count = 0;
    int send_wait = 0;
    int take_wait = 0;
    bit send_burst = 1'b0;
    bit take_burst = 1'b0;

    loud_sound_spike_detector_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_sample        (s_sample),
        .s_last_of_block (s_last_of_block),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_loud          (m_loud),
        .m_block_peak    (m_block_peak),
        .m_noise_level   (m_noise_level),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("Run stopped at the cycle limit with %0d reports outstanding.",
                     pending_reports.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Advances the predictor by one item; returns 1 when the item closes a block.
    function automatic bit predict_block_report(input mic_item_t it, output report_t rep);
        logic [16:0]                  mag;
        logic [lssd_pkg::SampleW-1:0] peak;
        logic [63:0]                  peak_q12;
        logic [63:0]                  mix;
        logic [lssd_pkg::AvgW-1:0]    floor_q8;
        rep = '0;
        if (it.cmd == CmdTick) begin
            if (hold_count != 0) begin
                hold_count--;
            end
            return 1'b0;
        end
        mag = it.pcm[lssd_pkg::SampleW-1] ? 17'h10000 - {1'b0, it.pcm} : {1'b0, it.pcm};
        if (mag[lssd_pkg::SampleW-1:0] > peak_track) begin
            peak_track = mag[lssd_pkg::SampleW-1:0];
        end
        if (!it.closes) begin
            return 1'b0;
        end
        peak = peak_track;
        peak_track = '0;
        // A silent block reports but neither adapts nor clamps the average.
        if (peak != 0) begin
            peak_q12 = 64'(peak) << 12;
            if (peak_q12 < 64'(avg_q8) * 64'(cfg_gate)) begin
                mix = 64'(avg_q8) * (64'd256 - 64'(cfg_weight))
                    + (64'(peak) << 8) * 64'(cfg_weight);
                avg_q8 = mix[31:8];
                adapt_steps++;
            end
            floor_q8 = {cfg_floor, 8'h00};
            if (avg_q8 < floor_q8) begin
                avg_q8 = floor_q8;
            end
            if (hold_count == 0 && peak_q12 > 64'(avg_q8) * 64'(cfg_spike)
                    && peak > cfg_min_peak) begin
                rep.loud = 1'b1;
                hold_count = cfg_refractory;
            end
        end
        rep.peak = peak;
        rep.level = avg_q8[lssd_pkg::AvgW-1:8];
        return 1'b1;
    endfunction

    // Per-item wait, with occasional switches into and out of back-to-back stretches.
    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 39) == 0) begin
            burst = !burst;
        end
        return burst ? 0 : $urandom_range(0, 6);
    endfunction

    always @(posedge aclk) begin : mic_driver
        report_t   rep;
        mic_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_valid && s_ready) begin
                items_sent++;
                if (predict_block_report({s_command, s_sample, s_last_of_block}, rep)) begin
                    pending_reports.push_back(rep);
                end
            end
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (mic_queue.size() > 0) begin
                    nxt = mic_queue.pop_front();
                    s_valid <= 1'b1;
                    s_command <= nxt.cmd;
                    s_sample <= nxt.pcm;
                    s_last_of_block <= nxt.closes;
                    send_wait = draw_gap(send_burst);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : report_monitor
        report_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            take_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                reports_checked++;
                if (m_loud) begin
                    loud_seen++;
                end
                if (pending_reports.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("Block report with none pending: loud=%0b peak=%0d level=%0d",
                                 m_loud, m_block_peak, m_noise_level);
                    end
                end else begin
                    want = pending_reports.pop_front();
                    if (m_loud !== want.loud || m_block_peak !== want.peak
                            || m_noise_level !== want.level) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display({"Report %0d mismatch: expected loud=%0b peak=%0d ",
                                      "level=%0d, got loud=%0b peak=%0d level=%0d"},
                                     reports_checked, want.loud, want.peak, want.level,
                                     m_loud, m_block_peak, m_noise_level);
                        end
                    end
                end
                take_wait = draw_gap(take_burst);
            end
            if (take_wait > 0) begin
                take_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_item(input logic cmd, input logic [lssd_pkg::SampleW-1:0] pcm,
                             input logic closes);
        mic_queue.push_back('{cmd: cmd, pcm: pcm, closes: closes});
    endtask

    function automatic logic [lssd_pkg::SampleW-1:0] draw_sample();
        logic [lssd_pkg::SampleW-1:0] m;
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1, 2, 3: m = 16'($urandom_range(0, 600));
            4: m = 16'($urandom_range(0, 50));
            5: m = 16'($urandom_range(0, 3500));
            6, 7: m = 16'($urandom_range(2000, 32767));
            default: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
        endcase
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    // Mostly complete blocks of a few samples, with ticks and stray samples mixed in.
    task automatic add_random_traffic(input int n);
        int added;
        int len;
        int r;
        added = 0;
        while (added < n) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                push_item(CmdTick, 16'($urandom), 1'($urandom));
                added++;
            end else if (r < 92) begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    push_item(CmdSample, draw_sample(), k == len - 1);
                end
                added += len;
            end else begin
                push_item(CmdSample, draw_sample(), 1'($urandom));
                added++;
            end
        end
    endtask

    // Returns once the detector has drained and had time to finish any trailing item.
    task automatic wait_idle();
        do @(negedge aclk);
        while (mic_queue.size() != 0 || s_valid || pending_reports.size() != 0);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [lssd_pkg::CfgIdxW-1:0] idx,
                             input logic [lssd_pkg::CfgDatW-1:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            lssd_pkg::RegSpikeRatio:  cfg_spike = data[lssd_pkg::RatioW-1:0];
            lssd_pkg::RegGateRatio:   cfg_gate = data[lssd_pkg::RatioW-1:0];
            lssd_pkg::RegMinPeak:     cfg_min_peak = data;
            lssd_pkg::RegNoiseFloor:  cfg_floor = data;
            lssd_pkg::RegAdaptWeight: cfg_weight = data[lssd_pkg::RatioW-1:0];
            lssd_pkg::RegRefractory:  cfg_refractory = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [lssd_pkg::CfgDatW-1:0] spike, gate, minp, flr,
                                  weight, refr);
        wait_idle();
        write_reg(lssd_pkg::RegSpikeRatio, spike);
        write_reg(lssd_pkg::RegGateRatio, gate);
        write_reg(lssd_pkg::RegMinPeak, minp);
        write_reg(lssd_pkg::RegNoiseFloor, flr);
        write_reg(lssd_pkg::RegAdaptWeight, weight);
        write_reg(lssd_pkg::RegRefractory, refr);
        write_reg($urandom_range(0, 1) ? RegSpareLo : RegSpareHi, 16'($urandom));
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
        @(negedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: silent block, adapt then clamp, full-scale spike, hold, ignored tick.
        push_item(CmdSample, 16'h0000, 1'b1);
        push_item(CmdSample, 16'd100, 1'b0);
        push_item(CmdSample, -16'sd200, 1'b0);
        push_item(CmdSample, 16'd50, 1'b1);
        push_item(CmdSample, 16'h8000, 1'b1);
        push_item(CmdSample, 16'h7FFF, 1'b1);
        push_item(CmdTick, 16'hFFFF, 1'b1);
        push_item(CmdSample, 16'hFFFF, 1'b0);
        push_item(CmdSample, 16'h0001, 1'b1);
        push_item(CmdSample, 16'd3001, 1'b1);

        // No refractory time and no adaptation weight: back-to-back loud blocks.
        apply_settings(16, 255, 0, 0, 0, 0);
        push_item(CmdSample, 16'd5000, 1'b1);
        push_item(CmdSample, 16'd6000, 1'b1);

        // Short hold that ticks clear, and a tick with the hold already at zero.
        apply_settings(16, 255, 0, 0, 0, 2);
        push_item(CmdSample, 16'd30000, 1'b1);
        push_item(CmdSample, 16'd30000, 1'b1);
        push_item(CmdTick, 16'h0000, 1'b0);
        push_item(CmdTick, 16'h0000, 1'b0);
        push_item(CmdSample, 16'd30000, 1'b1);
        repeat (3) push_item(CmdTick, 16'h0000, 1'b0);

        apply_settings(48, 32, 3000, 500, 13, 800);
        add_random_traffic(150);
        apply_settings(16, 16, 0, 0, 1, 0);
        add_random_traffic(150);
        apply_settings(255, 255, 32768, 32768, 128, 65535);
        add_random_traffic(150);
        // Values outside the documented ranges; upper data bits of 8-bit registers are dropped.
        apply_settings(16'hAB05, 16'h5400, 16'hFFFF, 16'hFFFF, 16'hFF00, 1);
        add_random_traffic(150);
        apply_settings(15, 200, 100, 50, 16'h00FF, 5);
        add_random_traffic(150);
        repeat (3) begin
            apply_settings(16'($urandom_range(16, 80)), 16'($urandom_range(16, 64)),
                           16'($urandom_range(0, 5000)), 16'($urandom_range(0, 1000)),
                           16'($urandom_range(1, 128)), 16'($urandom_range(0, 12)));
            add_random_traffic(150);
        end

        wait_idle();
        $display("Sent %0d items under %0d register settings; checked %0d block reports.",
                 items_sent, settings_used, reports_checked);
        $display("Saw %0d loud blocks and %0d noise average adaptations; %0d errors.",
                 loud_seen, adapt_steps, error_count);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lssd_pkg.sv
rtl/loud_sound_spike_detector_top.sv
rtl/lssd_checker.sv
sim/testbench.sv
